@@ src/sfd_pkg.sv @@
package sfd_pkg;

  // gain format, Q1.15 with 0x8000 as unity
  localparam int GAIN_W = 16;
  localparam int Q_FRAC = 15;
  localparam logic [GAIN_W-1:0] Q_ONE  = 16'h8000;
  localparam logic [GAIN_W-1:0] Q_HALF = 16'h4000;

  // config port
  localparam int DLEN_W    = 18;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_BLEND  = 3'd4;

  localparam logic [DLEN_W-1:0] DLEN_RESET  = 18'd24000;
  localparam logic [GAIN_W-1:0] FB_RESET    = 16'd16384;
  localparam logic [GAIN_W-1:0] MIX_RESET   = 16'd16384;
  localparam logic [GAIN_W-1:0] BLEND_RESET = 16'd32768;

  localparam logic MODE_MONO = 1'b0;
  localparam logic MODE_PING = 1'b1;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctrl_t;

  // gains above unity act as unity
  function automatic logic [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] g);
    return (g > Q_ONE) ? Q_ONE : g;
  endfunction

endpackage

@@ src/sfd_ram.sv @@
module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 131072
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/sfd_mac.sv @@
module sfd_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  sfd_pkg::mac_ctrl_t            ctrl,
  input  logic signed [SAMPLE_BITS-1:0] operand,
  input  logic [sfd_pkg::GAIN_W-1:0]    gain,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int ACC_W = SAMPLE_BITS + sfd_pkg::GAIN_W + 1;
  localparam int SH_W  = ACC_W - sfd_pkg::Q_FRAC;

  logic signed [sfd_pkg::GAIN_W:0] gain_s;
  logic signed [ACC_W-1:0]         prod;
  logic signed [ACC_W-1:0]         acc_r;
  logic signed [ACC_W-1:0]         acc_nxt;
  logic signed [ACC_W-1:0]         rnd;
  logic signed [SH_W-1:0]          sh;
  logic                            fits;

  // gain is never negative, zero-extend before the signed multiply
  assign gain_s = {1'b0, gain};
  assign prod   = operand * gain_s;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.en) begin
      acc_nxt = ctrl.clear ? prod : acc_r + prod;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round half up, then saturate to the sample width
  assign rnd  = acc_r + $signed(ACC_W'(sfd_pkg::Q_HALF));
  assign sh   = rnd[ACC_W-1:sfd_pkg::Q_FRAC];
  assign fits = (sh[SH_W-1:SAMPLE_BITS-1] == {(SH_W-SAMPLE_BITS+1){sh[SH_W-1]}});

  assign result = fits ? sh[SAMPLE_BITS-1:0]
                       : {sh[SH_W-1], {(SAMPLE_BITS-1){~sh[SH_W-1]}}};

endmodule

@@ src/stereo_feedback_delay.sv @@
// Stereo feedback delay with mono and ping-pong modes. Each accepted beat on
// the in_ channel carries one stereo sample and produces exactly one stereo
// beat on the out_ channel. The echo ring lives in two single-port-read RAMs
// (left and right, MAX_DELAY entries each); all gain products are done by one
// shared multiply-accumulate unit, two products per result. An item needs 4
// results in mono mode and 6 results in ping-pong mode; in_stall stays high
// from accept until the item is written back. The finished result sits in an
// output register, so a new item can be accepted while it waits to be taken.
// The ring reads as all zero after reset without a clearing pass: a fill
// count tracks how far the write pointer has ever got, and entries past it
// read as zero. Configuration is to be written through cfg_ only while the
// block is idle; the block itself does not enforce this. cfg_ready is always
// high and indexes beyond stereo_blend are ignored.
module stereo_feedback_delay #(
  parameter int MAX_DELAY   = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]        in_right_in,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_left_out,
  output logic signed [SAMPLE_BITS-1:0]        out_right_out,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfd_pkg::DLEN_W-1:0]           cfg_data
);

  localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int LEN_W = $clog2(MAX_DELAY + 1);
  localparam int CMP_W = (LEN_W > sfd_pkg::DLEN_W) ? LEN_W : sfd_pkg::DLEN_W;
  localparam int GW    = sfd_pkg::GAIN_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;  // ring address at the pointer
  localparam logic [2:0] ST_RDP  = 3'd2;  // pointer entry back, right tap address out
  localparam logic [2:0] ST_RDQ  = 3'd3;  // right tap back
  localparam logic [2:0] ST_MAC0 = 3'd4;  // first product of a result
  localparam logic [2:0] ST_MAC1 = 3'd5;  // second product of a result
  localparam logic [2:0] ST_WB   = 3'd6;  // ring write-back and output load

  // results computed by the shared unit, in order
  localparam logic [2:0] OP_DL = 3'd0;  // ping-pong blended left
  localparam logic [2:0] OP_DR = 3'd1;  // ping-pong blended right
  localparam logic [2:0] OP_OL = 3'd2;  // left output mix
  localparam logic [2:0] OP_OR = 3'd3;  // right output mix
  localparam logic [2:0] OP_NL = 3'd4;  // left feedback entry
  localparam logic [2:0] OP_NR = 3'd5;  // right feedback entry

  // config registers
  logic [sfd_pkg::DLEN_W-1:0] len_cfg_r, len_cfg_nxt;
  logic                       mode_r, mode_nxt;
  logic [GW-1:0]              fb_r, fb_nxt;
  logic [GW-1:0]              mix_r, mix_nxt;
  logic [GW-1:0]              blend_r, blend_nxt;

  // control
  logic [2:0]       state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic             pend_r, pend_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [PTR_W-1:0]              p_r, q_r;
  logic signed [SAMPLE_BITS-1:0] xl_r, xr_r, el_r, er_r, bt_r;
  logic signed [SAMPLE_BITS-1:0] dl_r, dr_r, ol_r, or_r, nl_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;

  logic [CMP_W-1:0]  len_wide;
  logic [LEN_W-1:0]  len_eff;
  logic [PTR_W-1:0]  p_eff;
  logic [LEN_W:0]    q_sum;
  logic [PTR_W-1:0]  q_calc;
  logic [LEN_W-1:0]  p_next;

  logic              accept;
  logic              out_free;
  logic              wb_go;
  logic              p_ok, q_ok;

  logic [GW-1:0] fb_g, mix_g, mix_c, w_g, w_c;

  logic signed [SAMPLE_BITS-1:0] l_rd, r_rd;
  logic [PTR_W-1:0]              r_rd_addr;

  sfd_pkg::mac_ctrl_t            mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] mac_a;
  logic [GW-1:0]                 mac_g;
  logic signed [SAMPLE_BITS-1:0] mac_res;

  // effective length: zero acts as one, clamp at the ring size
  assign len_wide = CMP_W'(len_cfg_r);
  always_comb begin
    if (len_cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_wide > CMP_W'(MAX_DELAY)) begin
      len_eff = LEN_W'(MAX_DELAY);
    end else begin
      len_eff = LEN_W'(len_wide);
    end
  end

  // pointer left past a shortened ring starts again at zero
  assign p_eff = (LEN_W'(wp_r) >= len_eff) ? '0 : wp_r;

  // right tap half a ring away, one wrap at most
  assign q_sum  = (LEN_W+1)'(p_r) + (LEN_W+1)'(len_eff >> 1);
  assign q_calc = (q_sum >= (LEN_W+1)'(len_eff)) ? PTR_W'(q_sum - (LEN_W+1)'(len_eff))
                                                 : PTR_W'(q_sum);

  assign p_next = LEN_W'(p_r) + LEN_W'(1);

  // entries beyond the fill count were never written and read as zero
  assign p_ok = (LEN_W'(p_r) < fill_r);
  assign q_ok = (LEN_W'(q_r) < fill_r);

  assign fb_g  = sfd_pkg::gain_clamp(fb_r);
  assign mix_g = sfd_pkg::gain_clamp(mix_r);
  assign w_g   = sfd_pkg::gain_clamp(blend_r);
  assign mix_c = sfd_pkg::Q_ONE - mix_g;
  assign w_c   = sfd_pkg::Q_ONE - w_g;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign wb_go    = (state_r == ST_WB) && out_free;

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  // ring storage
  assign r_rd_addr = (state_r == ST_RDP) ? q_r : p_r;

  sfd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_DELAY)
  ) u_ring_left (
    .clk    (clk),
    .wr_en  (wb_go),
    .wr_addr(p_r),
    .wr_data(nl_r),
    .rd_addr(p_r),
    .rd_data(l_rd)
  );

  sfd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_DELAY)
  ) u_ring_right (
    .clk    (clk),
    .wr_en  (wb_go),
    .wr_addr(p_r),
    .wr_data(mac_res),
    .rd_addr(r_rd_addr),
    .rd_data(r_rd)
  );

  // operand select: weighted sums a*g + b*(1-g), feedback e*fb + x*1
  always_comb begin
    mac_a = el_r;
    mac_g = fb_g;
    case (op_r)
      OP_DL: begin
        mac_a = (state_r == ST_MAC1) ? bt_r : el_r;
        mac_g = (state_r == ST_MAC1) ? w_c  : w_g;
      end
      OP_DR: begin
        mac_a = (state_r == ST_MAC1) ? el_r : bt_r;
        mac_g = (state_r == ST_MAC1) ? w_c  : w_g;
      end
      OP_OL: begin
        mac_a = (state_r == ST_MAC1) ? xl_r  : dl_r;
        mac_g = (state_r == ST_MAC1) ? mix_c : mix_g;
      end
      OP_OR: begin
        mac_a = (state_r == ST_MAC1) ? xr_r  : dr_r;
        mac_g = (state_r == ST_MAC1) ? mix_c : mix_g;
      end
      OP_NL: begin
        mac_a = (state_r == ST_MAC1) ? xl_r          : el_r;
        mac_g = (state_r == ST_MAC1) ? sfd_pkg::Q_ONE : fb_g;
      end
      OP_NR: begin
        mac_a = (state_r == ST_MAC1) ? xr_r          : er_r;
        mac_g = (state_r == ST_MAC1) ? sfd_pkg::Q_ONE : fb_g;
      end
      default: begin
        mac_a = el_r;
        mac_g = fb_g;
      end
    endcase
  end

  assign mac_ctrl.en    = (state_r == ST_MAC0) || (state_r == ST_MAC1);
  assign mac_ctrl.clear = (state_r == ST_MAC0);

  sfd_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .operand(mac_a),
    .gain   (mac_g),
    .result (mac_res)
  );

  // config writes
  always_comb begin
    len_cfg_nxt = len_cfg_r;
    mode_nxt    = mode_r;
    fb_nxt      = fb_r;
    mix_nxt     = mix_r;
    blend_nxt   = blend_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfd_pkg::CFG_DELAY_LENGTH:  len_cfg_nxt = cfg_data;
        sfd_pkg::CFG_MODE:          mode_nxt    = cfg_data[0];
        sfd_pkg::CFG_FEEDBACK_GAIN: fb_nxt      = cfg_data[GW-1:0];
        sfd_pkg::CFG_WET_MIX:       mix_nxt     = cfg_data[GW-1:0];
        sfd_pkg::CFG_STEREO_BLEND:  blend_nxt   = cfg_data[GW-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pend_nxt      = pend_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: state_nxt = ST_RDP;
      ST_RDP:  state_nxt = ST_RDQ;
      ST_RDQ: begin
        // mono skips the cross blend
        op_nxt    = (mode_r == sfd_pkg::MODE_PING) ? OP_DL : OP_OL;
        pend_nxt  = 1'b0;
        state_nxt = ST_MAC0;
      end
      ST_MAC0: state_nxt = ST_MAC1;
      ST_MAC1: begin
        pend_nxt = 1'b1;
        if (op_r == OP_NR) begin
          state_nxt = ST_WB;
        end else begin
          op_nxt    = op_r + 3'd1;
          state_nxt = ST_MAC0;
        end
      end
      ST_WB: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          wp_nxt        = (p_next >= len_eff) ? '0 : PTR_W'(p_next);
          if (p_next > fill_r) begin
            fill_nxt = p_next;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_DL;
      pend_r      <= 1'b0;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      len_cfg_r   <= sfd_pkg::DLEN_RESET;
      mode_r      <= sfd_pkg::MODE_MONO;
      fb_r        <= sfd_pkg::FB_RESET;
      mix_r       <= sfd_pkg::MIX_RESET;
      blend_r     <= sfd_pkg::BLEND_RESET;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      pend_r      <= pend_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      len_cfg_r   <= len_cfg_nxt;
      mode_r      <= mode_nxt;
      fb_r        <= fb_nxt;
      mix_r       <= mix_nxt;
      blend_r     <= blend_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      xl_r <= in_left_in;
      xr_r <= in_right_in;
      p_r  <= p_eff;
    end

    if (state_r == ST_ADDR) begin
      q_r <= q_calc;
    end

    if (state_r == ST_RDP) begin
      el_r <= p_ok ? l_rd : '0;
      er_r <= p_ok ? r_rd : '0;
      // mono mode uses the entry itself as the delayed sample
      dl_r <= p_ok ? l_rd : '0;
      dr_r <= p_ok ? r_rd : '0;
    end

    if (state_r == ST_RDQ) begin
      bt_r <= q_ok ? r_rd : '0;
    end

    // previous result leaves the accumulator as the next one starts
    if (state_r == ST_MAC0 && pend_r) begin
      case (op_r)
        OP_DR: dl_r <= mac_res;
        OP_OL: dr_r <= mac_res;
        OP_OR: ol_r <= mac_res;
        OP_NL: or_r <= mac_res;
        OP_NR: nl_r <= mac_res;
        default: begin
        end
      endcase
    end

    if (wb_go) begin
      out_left_r  <= ol_r;
      out_right_r <= or_r;
    end
  end

endmodule
